### hw/rtl/idll_pkg.sv
// shared types, constants and helpers for the indexed doubly linked list insert block
// no dependencies; imported by every other file of the block

package idll_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned SLOT_W   = 7;
  localparam int unsigned LINK_W   = 8;
  localparam int unsigned VALUE_W  = 32;

  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic [LINK_W-1:0]         link_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  localparam link_t NONE_LINK = link_t'(128);
  localparam link_t CAP_LINK  = link_t'(CAPACITY);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RDWAIT,
    S_WALK,
    S_FIX_CUR,
    S_FIX_SUCC,
    S_FIX_HEAD,
    S_DONE
  } state_e;

  typedef struct packed {
    value_t value;
    link_t  prev;
    link_t  next;
  } node_t;

  typedef struct packed {
    logic  rd_en;
    slot_t rd_addr;
    slot_t wr_addr;
    logic  we_value;
    logic  we_prev;
    logic  we_next;
    node_t wr_node;
  } ram_req_t;

  typedef struct packed {
    logic   status;
    slot_t  slot_index;
    value_t node_value;
    link_t  prev_slot;
    link_t  next_slot;
    link_t  head_slot;
  } res_t;

  function automatic logic link_valid(input link_t l);
    return l < CAP_LINK;
  endfunction

  // successor link a slot holds before it is ever written
  function automatic link_t reset_next(input slot_t a);
    logic [LINK_W:0] s;
    s = {2'b00, a} + (LINK_W+1)'(1);
    return (s < (LINK_W+1)'(CAPACITY)) ? s[LINK_W-1:0] : NONE_LINK;
  endfunction

endpackage

### hw/rtl/idll_if.sv
// valid/ready channel interfaces for request and response beats
// depends on idll_pkg

interface idll_in_if;
  import idll_pkg::*;
  logic   valid;
  logic   ready;
  logic   func;
  value_t value;
  logic [7:0] position;
  slot_t  slot;

  modport source (output valid, func, value, position, slot, input ready);
  modport sink   (input valid, func, value, position, slot, output ready);
endinterface

interface idll_out_if;
  import idll_pkg::*;
  logic   valid;
  logic   ready;
  logic   status;
  slot_t  slot_index;
  value_t node_value;
  link_t  prev_slot;
  link_t  next_slot;
  link_t  head_slot;

  modport source (output valid, status, slot_index, node_value, prev_slot, next_slot,
                  head_slot, input ready);
  modport sink   (input valid, status, slot_index, node_value, prev_slot, next_slot,
                  head_slot, output ready);
endinterface

### hw/rtl/indexed_doubly_linked_list_insert.sv
// Doubly linked list kept in a 128-slot node table, one request at a time. A read fetches
// the addressed slot's record from the node memory. An insert into an empty list or at
// position 1 writes the new node without a walk, and one refused for lack of a free slot
// writes nothing; any other insert first walks along successor links, one read of the node
// memory per cycle, to the node after which the new one goes, then relinks its neighbours.
// Link value 128 means none; slots are handed out in order and never freed.
// Depends on idll_pkg, idll_if, idll_node_ram, idll_seq and idll_out_reg.

module indexed_doubly_linked_list_insert import idll_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  idll_in_if.sink    req_i,
  idll_out_if.source rsp_o
);

  ram_req_t ram_req;
  node_t    rd_node;
  logic     res_valid;
  logic     res_ready;
  res_t     res;

  idll_node_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ram_req),
    .rd_node_o (rd_node)
  );

  idll_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .ram_req_o   (ram_req),
    .rd_node_i   (rd_node),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  idll_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .rsp_o       (rsp_o)
  );

endmodule

### hw/rtl/idll_node_ram.sv
// node table: one synchronous memory of value/prev/next records with field write enables
// depends on idll_pkg; successor links read as their reset chain until first written

module idll_node_ram import idll_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ram_req_t req_i,
  output node_t    rd_node_o
);

  node_t                 mem_q [CAPACITY];
  logic [CAPACITY-1:0]   nvld_q;
  node_t                 rdata_q;
  logic                  rd_vld_q;
  slot_t                 rd_addr_q;
  logic [ADDR_W-1:0]     wa;
  logic [ADDR_W-1:0]     ra;

  assign wa = req_i.wr_addr[ADDR_W-1:0];
  assign ra = req_i.rd_addr[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.we_value) begin
      mem_q[wa].value <= req_i.wr_node.value;
    end
    if (req_i.we_prev) begin
      mem_q[wa].prev <= req_i.wr_node.prev;
    end
    if (req_i.we_next) begin
      mem_q[wa].next <= req_i.wr_node.next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nvld_q <= '0;
    end else if (req_i.we_next) begin
      nvld_q[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q   <= mem_q[ra];
      rd_vld_q  <= nvld_q[ra];
      rd_addr_q <= req_i.rd_addr;
    end
  end

  always_comb begin
    rd_node_o       = rdata_q;
    rd_node_o.next  = rd_vld_q ? rdata_q.next : reset_next(rd_addr_q);
  end

endmodule

### hw/rtl/idll_seq.sv
// sequencer: takes one request, walks and relinks the node table, builds the response
// depends on idll_pkg and idll_if; drives idll_node_ram

module idll_seq import idll_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  idll_in_if.sink     req_i,
  output ram_req_t    ram_req_o,
  input  node_t       rd_node_i,
  output logic        res_valid_o,
  output res_t        res_o,
  input  logic        res_ready_i
);

  state_e     state_q, state_d;
  link_t      head_q, head_d;
  link_t      free_q, free_d;
  logic       func_q, func_d;
  value_t     value_q, value_d;
  logic [7:0] pos_q, pos_d;
  slot_t      slot_q, slot_d;
  slot_t      idx_q, idx_d;
  link_t      cur_q, cur_d;
  link_t      succ_q, succ_d;
  logic [7:0] cnt_q, cnt_d;
  res_t       res_q, res_d;
  logic       more;

  assign more = link_valid(rd_node_i.next) &&
                (({1'b0, cnt_q} + 9'd1) < {1'b0, pos_q});

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    free_d    = free_q;
    func_d    = func_q;
    value_d   = value_q;
    pos_d     = pos_q;
    slot_d    = slot_q;
    idx_d     = idx_q;
    cur_d     = cur_q;
    succ_d    = succ_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    ram_req_o = '0;
    req_i.ready = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          func_d  = req_i.func;
          value_d = req_i.value;
          pos_d   = req_i.position;
          slot_d  = req_i.slot;
          state_d = S_START;
        end
      end

      S_START: begin
        if (func_q == FUNC_READ) begin
          if (link_valid({1'b0, slot_q})) begin
            ram_req_o.rd_en   = 1'b1;
            ram_req_o.rd_addr = slot_q;
            state_d           = S_RDWAIT;
          end else begin
            res_d   = '{STATUS_DONE, slot_q, '0, NONE_LINK, NONE_LINK, head_q};
            state_d = S_DONE;
          end
        end else if (!link_valid(free_q)) begin
          res_d   = '{STATUS_FULL, '0, '0, NONE_LINK, NONE_LINK, head_q};
          state_d = S_DONE;
        end else begin
          idx_d  = free_q[SLOT_W-1:0];
          free_d = reset_next(free_q[SLOT_W-1:0]);
          cur_d  = head_q;
          cnt_d  = 8'd1;
          if (!link_valid(head_q)) begin
            // empty list: new node is the whole list
            ram_req_o.wr_addr  = free_q[SLOT_W-1:0];
            ram_req_o.we_value = 1'b1;
            ram_req_o.we_prev  = 1'b1;
            ram_req_o.we_next  = 1'b1;
            ram_req_o.wr_node  = '{value_q, NONE_LINK, NONE_LINK};
            head_d  = free_q;
            res_d   = '{STATUS_DONE, free_q[SLOT_W-1:0], value_q, NONE_LINK, NONE_LINK, free_q};
            state_d = S_DONE;
          end else if (pos_q == 8'd1) begin
            ram_req_o.wr_addr  = free_q[SLOT_W-1:0];
            ram_req_o.we_value = 1'b1;
            ram_req_o.we_prev  = 1'b1;
            ram_req_o.we_next  = 1'b1;
            ram_req_o.wr_node  = '{value_q, NONE_LINK, head_q};
            head_d  = free_q;
            res_d   = '{STATUS_DONE, free_q[SLOT_W-1:0], value_q, NONE_LINK, head_q, free_q};
            state_d = S_FIX_HEAD;
          end else begin
            ram_req_o.rd_en   = 1'b1;
            ram_req_o.rd_addr = head_q[SLOT_W-1:0];
            state_d           = S_WALK;
          end
        end
      end

      S_RDWAIT: begin
        res_d   = '{STATUS_DONE, slot_q, rd_node_i.value, rd_node_i.prev, rd_node_i.next,
                    head_q};
        state_d = S_DONE;
      end

      S_WALK: begin
        if (more) begin
          cur_d             = rd_node_i.next;
          cnt_d             = cnt_q + 8'd1;
          ram_req_o.rd_en   = 1'b1;
          ram_req_o.rd_addr = rd_node_i.next[SLOT_W-1:0];
        end else begin
          succ_d             = rd_node_i.next;
          ram_req_o.wr_addr  = idx_q;
          ram_req_o.we_value = 1'b1;
          ram_req_o.we_prev  = 1'b1;
          ram_req_o.we_next  = 1'b1;
          ram_req_o.wr_node  = '{value_q, cur_q, rd_node_i.next};
          res_d   = '{STATUS_DONE, idx_q, value_q, cur_q, rd_node_i.next, head_q};
          state_d = S_FIX_CUR;
        end
      end

      S_FIX_CUR: begin
        ram_req_o.wr_addr      = cur_q[SLOT_W-1:0];
        ram_req_o.we_next      = 1'b1;
        ram_req_o.wr_node.next = {1'b0, idx_q};
        state_d = link_valid(succ_q) ? S_FIX_SUCC : S_DONE;
      end

      S_FIX_SUCC: begin
        ram_req_o.wr_addr      = succ_q[SLOT_W-1:0];
        ram_req_o.we_prev      = 1'b1;
        ram_req_o.wr_node.prev = {1'b0, idx_q};
        state_d = S_DONE;
      end

      S_FIX_HEAD: begin
        // old head now follows the new node
        ram_req_o.wr_addr      = cur_q[SLOT_W-1:0];
        ram_req_o.we_prev      = 1'b1;
        ram_req_o.wr_node.prev = {1'b0, idx_q};
        state_d = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= NONE_LINK;
      free_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    value_q <= value_d;
    pos_q   <= pos_d;
    slot_q  <= slot_d;
    idx_q   <= idx_d;
    cur_q   <= cur_d;
    succ_q  <= succ_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
  end

endmodule

### hw/rtl/idll_out_reg.sv
// response output register between the sequencer and the response channel
// depends on idll_pkg and idll_if

module idll_out_reg import idll_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        res_valid_i,
  input  res_t        res_i,
  output logic        res_ready_o,
  idll_out_if.source  rsp_o
);

  logic out_valid_q, out_valid_d;
  res_t out_q;

  assign res_ready_o = !out_valid_q || rsp_o.ready;
  assign out_valid_d = res_valid_i || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      out_q <= res_i;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.slot_index = out_q.slot_index;
  assign rsp_o.node_value = out_q.node_value;
  assign rsp_o.prev_slot  = out_q.prev_slot;
  assign rsp_o.next_slot  = out_q.next_slot;
  assign rsp_o.head_slot  = out_q.head_slot;

endmodule

### hw/rtl/idll_checker.sv
// port-level checks for indexed_doubly_linked_list_insert, attached with a bind
// depends on idll_pkg

module idll_checker import idll_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   req_valid_i,
  input logic   req_ready_i,
  input logic   rsp_valid_i,
  input logic   rsp_ready_i,
  input logic   rsp_status_i,
  input slot_t  rsp_slot_index_i,
  input value_t rsp_node_value_i,
  input link_t  rsp_prev_i,
  input link_t  rsp_next_i,
  input link_t  rsp_head_i
);

  // stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i &&
      $stable({rsp_status_i, rsp_slot_index_i, rsp_node_value_i, rsp_prev_i, rsp_next_i,
               rsp_head_i}))
    else $error("response beat changed while stalled");

  // one request in flight at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in work");

  // refused insert carries no node and a nonempty list
  a_full_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == STATUS_FULL) |->
      (rsp_slot_index_i == '0) && (rsp_prev_i == NONE_LINK) &&
      (rsp_next_i == NONE_LINK) && (rsp_head_i != NONE_LINK))
    else $error("full response malformed");

endmodule

bind indexed_doubly_linked_list_insert idll_checker u_idll_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_status_i     (rsp_o.status),
  .rsp_slot_index_i (rsp_o.slot_index),
  .rsp_node_value_i (rsp_o.node_value),
  .rsp_prev_i       (rsp_o.prev_slot),
  .rsp_next_i       (rsp_o.next_slot),
  .rsp_head_i       (rsp_o.head_slot)
);
